// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm package
// request and result payloads and action codes of the i2c register master
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  target_addr;
    logic [7:0]  reg_addr;
    logic [15:0] byte_count;
    logic [3:0]  buffer_index;
    logic [7:0]  load_byte;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       nack_flag;
  } res_t;

  typedef logic [7:0] cfg_t;

endpackage

// ----- rtl/i2cm_chan_if.sv -----
// ----------------------------------------------------------------------------
// i2cm channel
// valid/ready channel carrying one payload per request
// ----------------------------------------------------------------------------
interface i2cm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/i2c_register_access_master_top.sv -----
// ----------------------------------------------------------------------------
// i2c register access master
// phase sequencer for i2c register writes and reads, one request per tick
// ----------------------------------------------------------------------------
//
//  channel | dir | payload | meaning
//  --------+-----+---------+-------------------------------------------------
//  req     | in  | req_t   | tick with sampled sda, buffer load, or start
//  res     | out | res_t   | bus drive levels, received byte, status
//  cfg     | in  | cfg_t   | phase length in ticks (bus speed)
//
// one request is taken every clock while the result queue is not full; each gives exactly one result
// the sequencer state and the phase timer update in the accepting cycle
// write data sits in a synchronous buffer memory read ahead into a register,
// with a forward path for a load into the slot being prefetched
// a two-entry result queue decouples the sides: req stalls only when full
// synchronous reset; the buffer contents are not cleared
//
`include "assert_macros.svh"

module i2c_register_access_master_top
  import i2cm_pkg::*;
#(
  parameter int BUF_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  i2cm_chan_if.sink      req,
  i2cm_chan_if.source    res,
  i2cm_chan_if.sink      cfg
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int PW = $clog2(BUF_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START_A   = 5'd1,
    ST_START_B   = 5'd2,
    ST_START_C   = 5'd3,
    ST_TX_LOW    = 5'd4,
    ST_TX_HIGH   = 5'd5,
    ST_ACKW_LOW  = 5'd6,
    ST_ACKW_HIGH = 5'd7,
    ST_RS_LOW    = 5'd8,
    ST_RX_LOW    = 5'd9,
    ST_RX_HIGH   = 5'd10,
    ST_RX_TAIL   = 5'd11,
    ST_ACKR_LOW  = 5'd12,
    ST_ACKR_HIGH = 5'd13,
    ST_ACKR_END  = 5'd14,
    ST_STOP_A    = 5'd15,
    ST_STOP_B    = 5'd16,
    ST_STOP_C    = 5'd17
  } step_t;

  typedef enum logic [1:0] {
    STG_DEV   = 2'd0,
    STG_REG   = 2'd1,
    STG_DATA  = 2'd2,
    STG_RDDEV = 2'd3
  } stage_t;

  // sequencer state
  step_t       step, step_next;
  stage_t      stage, stage_next;
  logic [7:0]  phase_timer, phase_timer_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        is_read, is_read_next;
  logic [7:0]  slave_addr, slave_addr_next;
  logic [7:0]  sub_addr, sub_addr_next;
  logic        nack_seen, nack_seen_next;
  logic [PW-1:0] buf_pos, buf_pos_next;
  logic [7:0]  phase_length;

  // write buffer memory and prefetch
  logic [7:0]    write_buffer [BUF_DEPTH];
  logic [7:0]    mem_q;
  logic          fwd_hit;
  logic [7:0]    fwd_byte;
  logic [PW-1:0] need_pos;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          load_ok;
  logic [7:0]    buf_byte;

  // result queue
  res_t        q0, q1, res_next;
  logic [1:0]  fill;
  logic        push, pop;

  logic [7:0]  len;
  logic [7:0]  timer_inc;
  logic [7:0]  rx_shift;
  logic        sda_s;
  req_t        r;

  assign r      = req.data;
  assign sda_s  = r.sda_in;
  assign push   = req.valid && req.ready;
  assign pop    = res.valid && res.ready;
  assign req.ready = (fill != 2'd2);
  assign res.valid = (fill != 2'd0);
  assign res.data  = q0;
  assign cfg.ready = 1'b1;

  // zero phase length behaves as one
  assign len       = (phase_length == 8'd0) ? 8'd1 : phase_length;
  assign timer_inc = phase_timer + 8'd1;
  assign rx_shift  = {shift_byte[6:0], sda_s};

  // the data path picks slot buf_pos after the register byte, buf_pos+1 after
  // each data byte; the address is settled many ticks before it is used
  assign need_pos = (stage == STG_DATA) ? buf_pos + PW'(1) : buf_pos;
  assign rd_addr  = (need_pos < PW'(BUF_DEPTH)) ? need_pos[AW-1:0] : '0;
  assign load_ok  = push && (r.action == ACT_LOAD) &&
                    ((BUF_DEPTH >= 16) || (r.buffer_index < 4'(BUF_DEPTH)));
  assign wr_addr  = AW'(r.buffer_index);
  assign buf_byte = fwd_hit ? fwd_byte : mem_q;

  always_ff @(posedge clk) begin
    if (load_ok) begin
      write_buffer[wr_addr] <= r.load_byte;
    end
    mem_q    <= write_buffer[rd_addr];
    // a load landing on the slot read this cycle overrides the stale read
    fwd_hit  <= load_ok && (wr_addr == rd_addr);
    fwd_byte <= r.load_byte;
  end

  always_comb begin
    step_next        = step;
    stage_next       = stage;
    phase_timer_next = phase_timer;
    bit_index_next   = bit_index;
    bytes_left_next  = bytes_left;
    shift_byte_next  = shift_byte;
    is_read_next     = is_read;
    slave_addr_next  = slave_addr;
    sub_addr_next    = sub_addr;
    nack_seen_next   = nack_seen;
    buf_pos_next     = buf_pos;
    res_next         = '0;

    // line drive for the phase in progress
    res_next.scl_out = 1'b1;
    res_next.sda_out = 1'b1;
    case (step)
      ST_START_B: res_next.sda_out = 1'b0;
      ST_START_C, ST_STOP_A: begin
        res_next.scl_out = 1'b0;
        res_next.sda_out = 1'b0;
      end
      ST_TX_LOW: begin
        res_next.scl_out = 1'b0;
        res_next.sda_out = shift_byte[7];
      end
      ST_TX_HIGH: res_next.sda_out = shift_byte[7];
      ST_ACKW_LOW, ST_RS_LOW, ST_RX_LOW, ST_RX_TAIL: res_next.scl_out = 1'b0;
      ST_ACKR_LOW, ST_ACKR_END: begin
        res_next.scl_out = 1'b0;
        res_next.sda_out = !(bytes_left > 16'd1);
      end
      ST_ACKR_HIGH: res_next.sda_out = !(bytes_left > 16'd1);
      ST_STOP_B: res_next.sda_out = 1'b0;
      default: ;
    endcase
    res_next.busy_res = (step != ST_IDLE);

    if (push) begin
      case (r.action)
        ACT_TICK: begin
          if (step != ST_IDLE) begin
            if (timer_inc >= len) begin
              phase_timer_next = 8'd0;
              case (step)
                ST_START_A: step_next = ST_START_B;
                ST_START_B: step_next = ST_START_C;
                ST_START_C: begin
                  shift_byte_next = (stage == STG_RDDEV) ? slave_addr + 8'd1 : slave_addr;
                  bit_index_next  = 3'd0;
                  step_next       = ST_TX_LOW;
                end
                ST_TX_LOW: step_next = ST_TX_HIGH;
                ST_TX_HIGH: begin
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                  if (bit_index == 3'd7) begin
                    step_next = ST_ACKW_LOW;
                  end else begin
                    bit_index_next = bit_index + 3'd1;
                    step_next      = ST_TX_LOW;
                  end
                end
                ST_ACKW_LOW: step_next = ST_ACKW_HIGH;
                ST_ACKW_HIGH: begin
                  // missing ack is only recorded
                  if (sda_s) begin
                    nack_seen_next = 1'b1;
                  end
                  case (stage)
                    STG_DEV: begin
                      stage_next      = STG_REG;
                      shift_byte_next = sub_addr;
                      bit_index_next  = 3'd0;
                      step_next       = ST_TX_LOW;
                    end
                    STG_REG: begin
                      if (is_read) begin
                        step_next = ST_RS_LOW;
                      end else if (bytes_left != 16'd0) begin
                        stage_next      = STG_DATA;
                        shift_byte_next = buf_byte;
                        bit_index_next  = 3'd0;
                        step_next       = ST_TX_LOW;
                      end else begin
                        step_next = ST_STOP_A;
                      end
                    end
                    STG_DATA: begin
                      buf_pos_next = buf_pos + PW'(1);
                      if (bytes_left > 16'd1) begin
                        bytes_left_next = bytes_left - 16'd1;
                        shift_byte_next = buf_byte;
                        bit_index_next  = 3'd0;
                        step_next       = ST_TX_LOW;
                      end else begin
                        bytes_left_next = 16'd0;
                        step_next       = ST_STOP_A;
                      end
                    end
                    default: begin
                      bit_index_next  = 3'd0;
                      shift_byte_next = 8'd0;
                      step_next       = ST_RX_LOW;
                    end
                  endcase
                end
                ST_RS_LOW: begin
                  stage_next = STG_RDDEV;
                  step_next  = ST_START_A;
                end
                ST_RX_LOW: step_next = ST_RX_HIGH;
                ST_RX_HIGH: begin
                  shift_byte_next = rx_shift;
                  if (bit_index == 3'd7) begin
                    res_next.read_valid = 1'b1;
                    res_next.read_data  = rx_shift;
                    res_next.read_last  = (bytes_left <= 16'd1);
                    step_next           = ST_RX_TAIL;
                  end else begin
                    bit_index_next = bit_index + 3'd1;
                    step_next      = ST_RX_LOW;
                  end
                end
                ST_RX_TAIL: step_next = ST_ACKR_LOW;
                ST_ACKR_LOW: step_next = ST_ACKR_HIGH;
                ST_ACKR_HIGH: step_next = ST_ACKR_END;
                ST_ACKR_END: begin
                  if (bytes_left > 16'd1) begin
                    bytes_left_next = bytes_left - 16'd1;
                    bit_index_next  = 3'd0;
                    shift_byte_next = 8'd0;
                    step_next       = ST_RX_LOW;
                  end else begin
                    bytes_left_next = 16'd0;
                    step_next       = ST_STOP_A;
                  end
                end
                ST_STOP_A: step_next = ST_STOP_B;
                ST_STOP_B: step_next = ST_STOP_C;
                ST_STOP_C: begin
                  step_next         = ST_IDLE;
                  res_next.done_res = 1'b1;
                end
                default: step_next = ST_IDLE;
              endcase
            end else begin
              phase_timer_next = timer_inc;
            end
          end
        end
        ACT_LOAD: ;
        default: begin
          // start request, ignored while a transfer runs
          if (step == ST_IDLE) begin
            slave_addr_next  = r.target_addr;
            sub_addr_next    = r.reg_addr;
            nack_seen_next   = 1'b0;
            stage_next       = STG_DEV;
            buf_pos_next     = '0;
            bit_index_next   = 3'd0;
            shift_byte_next  = 8'd0;
            phase_timer_next = 8'd0;
            if (r.action == ACT_WRITE) begin
              is_read_next    = 1'b0;
              bytes_left_next = (r.byte_count > 16'(BUF_DEPTH)) ? 16'(BUF_DEPTH)
                                                                : r.byte_count;
            end else begin
              is_read_next    = 1'b1;
              bytes_left_next = (r.byte_count == 16'd0) ? 16'd1 : r.byte_count;
            end
            step_next = ST_START_A;
          end
        end
      endcase
    end
    res_next.nack_flag = nack_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      stage        <= STG_DEV;
      phase_timer  <= 8'd0;
      bit_index    <= 3'd0;
      bytes_left   <= 16'd0;
      shift_byte   <= 8'd0;
      is_read      <= 1'b0;
      slave_addr   <= 8'd0;
      sub_addr     <= 8'd0;
      nack_seen    <= 1'b0;
      buf_pos      <= '0;
      phase_length <= 8'd1;
      fill         <= 2'd0;
    end else begin
      step        <= step_next;
      stage       <= stage_next;
      phase_timer <= phase_timer_next;
      bit_index   <= bit_index_next;
      bytes_left  <= bytes_left_next;
      shift_byte  <= shift_byte_next;
      is_read     <= is_read_next;
      slave_addr  <= slave_addr_next;
      sub_addr    <= sub_addr_next;
      nack_seen   <= nack_seen_next;
      buf_pos     <= buf_pos_next;
      if (cfg.valid && cfg.ready) begin
        phase_length <= cfg.data;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // result queue payload, head in q0
  always_ff @(posedge clk) begin
    if (pop && (fill == 2'd2)) begin
      q0 <= q1;
    end
    if (push) begin
      if ((fill == 2'd0) || ((fill == 2'd1) && pop)) begin
        q0 <= res_next;
      end else begin
        q1 <= res_next;
      end
    end
  end

  `ASSERT_SAME(a_idle_timer, clk, rst, step == ST_IDLE, phase_timer == 8'd0)
  `ASSERT_SAME(a_data_is_write, clk, rst, stage == STG_DATA, !is_read)
  `ASSERT_SAME(a_full_stalls, clk, rst, fill == 2'd2, !req.ready && res.valid)
  `ASSERT_NEXT(a_push_shows, clk, rst, push && (fill == 2'd0), res.valid)

endmodule
